FILE: rtl/bounded_integer_set_table_macros.svh
// Assertion macros for the bounded integer set table.
// Taken in by the files that check their own logic; no other dependencies.
`ifndef BOUNDED_INTEGER_SET_TABLE_MACROS_SVH
`define BOUNDED_INTEGER_SET_TABLE_MACROS_SVH
`ifndef SYNTH
// Expression must hold at every clock edge out of reset.
`define BIST_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("bist: assertion failed");
// When the antecedent holds, the consequent must hold in the next cycle.
`define BIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bist: assertion failed");
`else
`define BIST_ASSERT(lbl, clk, rst_n, expr)
`define BIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/bist_pkg.sv
// Shared types and constants of the bounded integer set table.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none
package bist_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int OP_W      = 2;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               add;
    logic               rem;
    logic [VALUE_W-1:0] key;
    logic [VALUE_W-1:0] last_word;
  } cell_cmd_t;

  // Passed from each cell to its lower neighbor.
  typedef struct packed {
    logic               hit;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] last_word;
  } cell_link_t;

endpackage
`default_nettype wire

FILE: rtl/bist_req_if.sv
// Request channel of the bounded integer set table: valid, ready, op, value.
// Depends on bist_pkg.
`default_nettype none
interface bist_req_if import bist_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface
`default_nettype wire

FILE: rtl/bist_rsp_if.sv
// Result channel of the bounded integer set table: valid, ready and result fields.
// Depends on bist_pkg.
`default_nettype none
interface bist_rsp_if import bist_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;
  logic                is_full;

  modport source (output valid, status, found, position, count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, status, found, position, count, is_empty, is_full,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/bist_cell.sv
// One slot of the set table: holds an entry, compares it with the key and
// merges its match and last-entry word into the link from its upper neighbor.
// Depends on bist_pkg.
`default_nettype none
module bist_cell import bist_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire logic [CNT_W-1:0] cnt,
  input  wire cell_cmd_t        cmd,
  input  wire cell_link_t       link_in,
  output      cell_link_t       link_out
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(INDEX + 1);
  localparam logic [POS_W-1:0] MY_POS  = POS_W'(INDEX);

  logic [VALUE_W-1:0] entry_r;
  logic               occupied;
  logic               hit;
  logic               is_last;

  assign occupied = MY_IDX < cnt;
  assign hit      = occupied && (entry_r == cmd.key);
  assign is_last  = MY_NEXT == cnt;

  // The set never holds duplicates, so at most one cell contributes a position.
  always_comb begin
    link_out.hit       = link_in.hit | hit;
    link_out.pos       = link_in.pos | (hit ? MY_POS : '0);
    link_out.last_word = link_in.last_word | (is_last ? entry_r : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.add && (MY_IDX == cnt)) begin
      entry_r <= cmd.key;
    end else if (cmd.rem && hit) begin
      entry_r <= cmd.last_word;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bounded_integer_set_table.sv
// Top level of the bounded integer set table: controller, row of cells, result register.
// Depends on bist_pkg, bist_req_if, bist_rsp_if, bist_cell and the assertion macros.
`default_nettype none
`include "bounded_integer_set_table_macros.svh"

// The block keeps a set of distinct signed 32-bit values in a row of DEPTH cells,
// slots 0 up to the count minus one. Each request item adds, removes or looks up
// one value and yields exactly one result item with status, presence, slot, the
// new count and the empty and full flags. An add appends at the slot named by the
// count unless the value is already present or the count has reached the smaller
// of capacity_limit and DEPTH; a remove copies the last entry into the freed slot.
// An item is accepted into the request register while idle; in the work state
// every cell compares its entry with the value, the match, its slot and the last
// entry ripple down the row, and the cells, the count and the result register are
// updated together. The next item is taken in the cycle after that, so no new item
// is taken before the last is through; the row's search and update pass sets the
// pace. The work state waits only while the result register holds an untaken item.
// capacity_limit is written through cfg_we and cfg_wdata; the user must do so only
// while the block is idle, which the block does not enforce. It resets to 64. Entries
// have no reset; the count resets to zero, so no slot is read before it is written.
module bounded_integer_set_table import bist_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bist_req_if.sink              in_ch,
  bist_rsp_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    req_op_r;
  logic [VALUE_W-1:0] req_value_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CAP_W-1:0]   cap_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_found_r;
  logic [POS_W-1:0]    out_position_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_is_empty_r;
  logic                out_is_full_r;

  cell_cmd_t  cmd;
  cell_link_t link [0:DEPTH];

  logic             in_fire;
  logic             out_free;
  logic             commit;
  logic             is_add;
  logic             is_rem;
  logic             hit;
  logic             full_now;
  logic             add_ok;
  logic             rem_ok;
  logic [LIM_W-1:0] cap_ext;
  logic [LIM_W-1:0] eff_limit;

  logic [STATUS_W-1:0] status_c;
  logic [POS_W-1:0]    position_c;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // The effective limit is the smaller of capacity_limit and the row length.
  always_comb begin
    cap_ext   = LIM_W'(cap_r);
    eff_limit = (cap_ext < LIM_W'(DEPTH)) ? cap_ext : LIM_W'(DEPTH);
    full_now  = LIM_W'(count_r) >= eff_limit;
  end

  // Request register and sequencer.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign commit      = (state_r == S_WORK) && out_free;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op_r    <= in_ch.op;
      req_value_r <= in_ch.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Decode the held request against the row's answer. Op code 3 acts as a lookup.
  always_comb begin
    is_add = (req_op_r == OP_ADD);
    is_rem = (req_op_r == OP_REMOVE);
    hit    = link[0].hit;
    add_ok = is_add && !hit && !full_now;
    rem_ok = is_rem && hit;

    cmd.add       = commit && add_ok;
    cmd.rem       = commit && rem_ok;
    cmd.key       = req_value_r;
    cmd.last_word = link[0].last_word;

    if (is_add) begin
      if (hit) begin
        status_c = ST_PRESENT;
      end else if (full_now) begin
        status_c = ST_FULL;
      end else begin
        status_c = ST_DONE;
      end
    end else begin
      status_c = hit ? ST_DONE : ST_NOT_FOUND;
    end

    if (hit) begin
      position_c = link[0].pos;
    end else if (add_ok) begin
      position_c = POS_W'(count_r);
    end else begin
      position_c = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (commit) begin
          state_nxt = S_IDLE;
          if (add_ok) begin
            count_nxt = count_r + CNT_W'(1);
          end else if (rem_ok) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Row of cells. The top end of the link chain starts empty; slot 0's link
  // carries the merged answer of the whole row.
  assign link[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bist_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .cnt      (count_r),
      .cmd      (cmd),
      .link_in  (link[i+1]),
      .link_out (link[i])
    );
  end

  // Result register: it holds a finished item until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r   <= status_c;
      out_found_r    <= hit;
      out_position_r <= position_c;
      out_count_r    <= COUNT_W'(count_nxt);
      out_is_empty_r <= (count_nxt == '0);
      out_is_full_r  <= LIM_W'(count_nxt) >= eff_limit;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_position_r;
  assign out_ch.count    = out_count_r;
  assign out_ch.is_empty = out_is_empty_r;
  assign out_ch.is_full  = out_is_full_r;

  // The count never runs past the row.
  `BIST_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH))
  // The count moves only when an item is finished.
  `BIST_ASSERT_NEXT(a_count_idle, clk, rst_n, state_r == S_IDLE, count_r == $past(count_r))
  // A finished item is always presented on the result channel.
  `BIST_ASSERT_NEXT(a_commit_out, clk, rst_n, commit, out_valid_r)
  // A successful remove shrinks the set by exactly one entry.
  `BIST_ASSERT_NEXT(a_remove_dec, clk, rst_n, cmd.rem, count_r == $past(count_r) - CNT_W'(1))

endmodule
`default_nettype wire
